// ----- design/bpc_pkg.sv -----
// Package for the barometric temperature and pressure compensation core.
// Holds shared types, pipeline depths and fixed-point helper functions.
// No dependencies.
`default_nettype none
package bpc_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PRESS = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] temp;
    logic               neg;
  } side_t;

  localparam int PreStages  = 14;
  localparam int DivBits    = 34;
  localparam int PostStages = 6;
  localparam int Latency    = PreStages + DivBits + PostStages;

  localparam logic signed [79:0] Max32    = 80'sd2147483647;
  localparam logic signed [79:0] Min32    = -80'sd2147483648;
  localparam logic signed [79:0] Max16    = 80'sd32767;
  localparam logic signed [79:0] Min16    = -80'sd32768;
  localparam logic signed [79:0] MaxPress = 80'sd1048575;
  localparam logic signed [79:0] TFineOff = 80'sd128000;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [79:0] r;
    if (v > Max32) begin
      r = Max32;
    end else if (v < Min32) begin
      r = Min32;
    end else begin
      r = v;
    end
    return 32'(r);
  endfunction

  // Division by 2^k with truncation toward zero.
  function automatic logic signed [79:0] tdiv(input logic signed [79:0] v,
                                              input logic [6:0] k);
    logic signed [79:0] bias;
    bias = v[79] ? ((80'sd1 <<< k) - 80'sd1) : 80'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage
`default_nettype wire

// ----- design/bpc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Carries a side-band struct alongside each beat; uses bpc_pkg.
`default_nettype none
module bpc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [bpc_pkg::DivBits-1:0] in_dvd,
  input  wire logic [31:0]                 in_dvs,
  input  wire bpc_pkg::side_t              in_side,
  output logic                             out_vld,
  output logic [bpc_pkg::DivBits-1:0]      out_quo,
  output bpc_pkg::side_t                   out_side
);

  localparam int N = bpc_pkg::DivBits;

  logic [N-1:0]   vld_r;
  logic [N-1:0]   dvd_r  [N];
  logic [N-1:0]   dvd_nxt[N];
  logic [N-1:0]   quo_r  [N];
  logic [N-1:0]   quo_nxt[N];
  logic [31:0]    rem_r  [N];
  logic [31:0]    rem_nxt[N];
  logic [31:0]    dvs_r  [N];
  bpc_pkg::side_t side_r [N];

  always_comb begin
    logic [N-1:0] s_dvd;
    logic [N-1:0] s_quo;
    logic [31:0]  s_rem;
    logic [31:0]  s_dvs;
    logic [32:0]  trial;
    logic         ge;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        s_dvd = in_dvd;
        s_quo = '0;
        s_rem = '0;
        s_dvs = in_dvs;
      end else begin
        s_dvd = dvd_r[s-1];
        s_quo = quo_r[s-1];
        s_rem = rem_r[s-1];
        s_dvs = dvs_r[s-1];
      end
      trial      = {s_rem, s_dvd[N-1]};
      ge         = (trial >= {1'b0, s_dvs});
      rem_nxt[s] = ge ? 32'(trial - {1'b0, s_dvs}) : trial[31:0];
      quo_nxt[s] = {s_quo[N-2:0], ge};
      dvd_nxt[s] = {s_dvd[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      dvd_r[s] <= dvd_nxt[s];
      quo_r[s] <= quo_nxt[s];
      rem_r[s] <= rem_nxt[s];
    end
    dvs_r[0]  <= in_dvs;
    side_r[0] <= in_side;
    for (int s = 1; s < N; s++) begin
      dvs_r[s]  <= dvs_r[s-1];
      side_r[s] <= side_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_quo  = quo_r[N-1];
  assign out_side = side_r[N-1];

endmodule
`default_nettype wire

// ----- design/baro_temp_pressure_compensation_core.sv -----
// Top level of the barometric temperature and pressure compensation core.
// Uses bpc_pkg and bpc_div.
//
// The core takes one beat in every clock cycle while busy is low and returns
// each result in order; busy is high during reset and for the first cycle after
// reset is released. The pipeline consists of fourteen stages of calibration
// arithmetic, the 34-stage restoring divider that forms the pressure quotient,
// and six stages of final correction and output registering. Results appear
// for exactly one cycle on out_valid and cannot be held off. Calibration
// registers are 48 bits at byte addresses 0, 8, 16 and 24 and should be
// written only while no beat is in flight.
`default_nettype none
module baro_temp_pressure_compensation_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] in_raw_temperature,
  input  wire logic [19:0] in_raw_pressure,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic signed [15:0] out_temperature_tenths,
  output logic [19:0]      out_pressure_pa,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int PS = bpc_pkg::PreStages;

  logic [47:0] temp_calib_r, press_a_r, press_b_r, press_c_r;
  logic        busy_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
    end else if (wr_en) begin
      unique case (bpc_pkg::reg_idx_t'(paddr[4:3]))
        bpc_pkg::REG_TEMP:    temp_calib_r <= pwdata[47:0];
        bpc_pkg::REG_PRESS_A: press_a_r    <= pwdata[47:0];
        bpc_pkg::REG_PRESS_B: press_b_r    <= pwdata[47:0];
        bpc_pkg::REG_PRESS_C: press_c_r    <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bpc_pkg::reg_idx_t'(paddr[4:3]))
      bpc_pkg::REG_TEMP:    prdata = {16'b0, temp_calib_r};
      bpc_pkg::REG_PRESS_A: prdata = {16'b0, press_a_r};
      bpc_pkg::REG_PRESS_B: prdata = {16'b0, press_b_r};
      bpc_pkg::REG_PRESS_C: prdata = {16'b0, press_c_r};
      default:              prdata = '0;
    endcase
  end

  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [16:0] p1, m9;

  assign t2 = $signed(temp_calib_r[31:16]);
  assign t3 = $signed(temp_calib_r[47:32]);
  assign p1 = $signed({1'b0, press_a_r[15:0]});
  assign p2 = $signed(press_a_r[31:16]);
  assign p3 = $signed(press_a_r[47:32]);
  assign p4 = $signed(press_b_r[15:0]);
  assign p5 = $signed(press_b_r[31:16]);
  assign p6 = $signed(press_b_r[47:32]);
  assign p7 = $signed(press_c_r[15:0]);
  assign p8 = $signed(press_c_r[31:16]);
  assign p9 = $signed(press_c_r[47:32]);
  assign m9 = p9[15] ? -17'(p9) : 17'(p9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  logic [PS-1:0] vld_r;

  logic signed [21:0] d1_r, d1_nxt;
  logic signed [37:0] m1_2_r, m1_2_nxt;
  logic signed [43:0] dd2_r, dd2_nxt;
  logic signed [23:0] v1_3_r, v1_3_nxt;
  logic signed [59:0] m2_3_r, m2_3_nxt;
  logic signed [24:0] tf4_r, tf4_nxt;
  logic signed [15:0] temp5_nxt;
  logic signed [24:0] a5_r, a5_nxt;
  logic signed [49:0] aa6_r, aa6_nxt;
  logic signed [40:0] ap5_6_r, ap5_6_nxt, ap2_6_r, ap2_6_nxt, ap5_7_r, ap2_7_r, ap5_8_r;
  logic signed [65:0] x6_7_r, x6_7_nxt, x3_7_r, x3_7_nxt;
  logic signed [31:0] v2a8_r, v2a8_nxt, b8_r, b8_nxt;
  logic signed [31:0] v2b9_r, v2b9_nxt;
  logic signed [32:0] c9_r, c9_nxt;
  logic signed [31:0] v2c10_r, v2c10_nxt, v2c11_r;
  logic signed [49:0] m10_r, m10_nxt;
  logic signed [31:0] v1p11_r, v1p11_nxt, v1p12_r, v1p13_r;
  logic signed [34:0] num12_r, num12_nxt;
  logic signed [48:0] num13_r, num13_nxt;
  bpc_pkg::status_t   st12_r, st12_nxt, st13_r;
  logic [19:0]        adcp_r [1:11];
  logic signed [15:0] temp_r [5:13];

  logic [bpc_pkg::DivBits-1:0] dvd14_r, dvd14_nxt;
  logic [31:0]                 dvs14_r, dvs14_nxt;
  bpc_pkg::side_t              side14_r, side14_nxt;

  always_comb begin
    logic signed [79:0] tq;
    logic signed [48:0] mag;
    logic signed [32:0] dmag;
    logic [20:0]        pinv;

    d1_nxt   = $signed({2'b0, in_raw_temperature}) - $signed({2'b0, temp_calib_r[15:0], 4'b0});
    m1_2_nxt = d1_r * t2;
    dd2_nxt  = d1_r * d1_r;
    v1_3_nxt = 24'(bpc_pkg::tdiv(80'(m1_2_r), 7'd14));
    m2_3_nxt = dd2_r * t3;
    tf4_nxt  = 25'(v1_3_r) + 25'(bpc_pkg::tdiv(80'(m2_3_r), 7'd34));

    tq = bpc_pkg::tdiv(80'(tf4_r), 7'd9);
    if (tq > bpc_pkg::Max16) begin
      temp5_nxt = 16'sh7FFF;
    end else if (tq < bpc_pkg::Min16) begin
      temp5_nxt = -16'sh8000;
    end else begin
      temp5_nxt = 16'(tq);
    end
    a5_nxt = 25'(bpc_pkg::tdiv(80'(tf4_r) - bpc_pkg::TFineOff, 7'd1));

    aa6_nxt   = a5_r * a5_r;
    ap5_6_nxt = a5_r * p5;
    ap2_6_nxt = a5_r * p2;
    x6_7_nxt  = aa6_r * p6;
    x3_7_nxt  = aa6_r * p3;
    v2a8_nxt  = bpc_pkg::sat32(bpc_pkg::tdiv(80'(x6_7_r), 7'd15));
    b8_nxt    = bpc_pkg::sat32(bpc_pkg::tdiv(80'(x3_7_r) + (80'(ap2_7_r) <<< 19), 7'd38));
    v2b9_nxt  = bpc_pkg::sat32(80'(v2a8_r) + (80'(ap5_8_r) <<< 1));
    c9_nxt    = 33'(b8_r) + 33'sd32768;
    v2c10_nxt = bpc_pkg::sat32(bpc_pkg::tdiv(80'(v2b9_r) + (80'(p4) <<< 18), 7'd2));
    m10_nxt   = c9_r * p1;
    v1p11_nxt = bpc_pkg::sat32(bpc_pkg::tdiv(80'(m10_r), 7'd15));

    pinv      = 21'd1048576 - {1'b0, adcp_r[11]};
    num12_nxt = $signed({2'b0, pinv, 12'b0}) - 35'(v2c11_r);
    if (adcp_r[11] == 20'd0) begin
      st12_nxt = bpc_pkg::ST_NO_PRESS;
    end else if (v1p11_r == 32'sd0) begin
      st12_nxt = bpc_pkg::ST_DIV_ZERO;
    end else begin
      st12_nxt = bpc_pkg::ST_OK;
    end
    num13_nxt = num12_r * 14'sd6250;

    mag       = num13_r[48] ? -num13_r : num13_r;
    dmag      = v1p13_r[31] ? -33'(v1p13_r) : 33'(v1p13_r);
    dvd14_nxt = mag[45:12];
    dvs14_nxt = dmag[31:0];
    side14_nxt.status = st13_r;
    side14_nxt.temp   = temp_r[13];
    side14_nxt.neg    = num13_r[48] ^ v1p13_r[31];
  end

  always_ff @(posedge clk) begin
    d1_r     <= d1_nxt;
    m1_2_r   <= m1_2_nxt;
    dd2_r    <= dd2_nxt;
    v1_3_r   <= v1_3_nxt;
    m2_3_r   <= m2_3_nxt;
    tf4_r    <= tf4_nxt;
    a5_r     <= a5_nxt;
    aa6_r    <= aa6_nxt;
    ap5_6_r  <= ap5_6_nxt;
    ap2_6_r  <= ap2_6_nxt;
    x6_7_r   <= x6_7_nxt;
    x3_7_r   <= x3_7_nxt;
    ap5_7_r  <= ap5_6_r;
    ap2_7_r  <= ap2_6_r;
    ap5_8_r  <= ap5_7_r;
    v2a8_r   <= v2a8_nxt;
    b8_r     <= b8_nxt;
    v2b9_r   <= v2b9_nxt;
    c9_r     <= c9_nxt;
    v2c10_r  <= v2c10_nxt;
    m10_r    <= m10_nxt;
    v2c11_r  <= v2c10_r;
    v1p11_r  <= v1p11_nxt;
    v1p12_r  <= v1p11_r;
    num12_r  <= num12_nxt;
    st12_r   <= st12_nxt;
    v1p13_r  <= v1p12_r;
    num13_r  <= num13_nxt;
    st13_r   <= st12_r;
    dvd14_r  <= dvd14_nxt;
    dvs14_r  <= dvs14_nxt;
    side14_r <= side14_nxt;
    adcp_r[1] <= in_raw_pressure;
    for (int k = 2; k <= 11; k++) begin
      adcp_r[k] <= adcp_r[k-1];
    end
    temp_r[5] <= temp5_nxt;
    for (int k = 6; k <= 13; k++) begin
      temp_r[k] <= temp_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PS-2:0], start & ~busy_r};
    end
  end

  logic                        dq_vld;
  logic [bpc_pkg::DivBits-1:0] dq_quo;
  bpc_pkg::side_t              dq_side;

  bpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[PS-1]),
    .in_dvd   (dvd14_r),
    .in_dvs   (dvs14_r),
    .in_side  (side14_r),
    .out_vld  (dq_vld),
    .out_quo  (dq_quo),
    .out_side (dq_side)
  );

  logic [4:0]         pvld_r;
  bpc_pkg::side_t     pside_r [5];
  logic signed [31:0] p1q_r, p1q_nxt, p2q_r, p3q_r;
  logic signed [63:0] sq_r, sq_nxt;
  logic signed [47:0] pp8_r, pp8_nxt;
  logic signed [80:0] y_r, y_nxt;
  logic signed [31:0] v2q_r, v2q_nxt, v1s_r, v1s_nxt;
  logic signed [37:0] t_r, t_nxt;
  logic signed [38:0] s_r, s_nxt;
  bpc_pkg::status_t   out_st_r;
  logic signed [15:0] out_temp_r, out_temp_nxt;
  logic [19:0]        out_press_r, out_press_nxt;
  logic               out_valid_r;

  always_comb begin
    logic signed [34:0] negq;
    logic signed [80:0] yq;
    logic signed [79:0] r;

    negq = -$signed({1'b0, dq_quo});
    if (dq_side.neg) begin
      p1q_nxt = (dq_quo > 34'd2147483648) ? -32'sh80000000 : 32'(negq);
    end else begin
      p1q_nxt = (dq_quo > 34'd2147483647) ? 32'sh7FFFFFFF : $signed(dq_quo[31:0]);
    end
    sq_nxt  = p1q_r * p1q_r;
    pp8_nxt = p1q_r * p8;
    y_nxt   = sq_r * m9;
    v2q_nxt = bpc_pkg::sat32(bpc_pkg::tdiv(80'(pp8_r), 7'd15));
    yq      = y_r >>> 31;
    v1s_nxt = bpc_pkg::sat32(p9[15] ? -80'(yq) : 80'(yq));
    t_nxt   = (38'(p3q_r) <<< 4) + 38'(v2q_r) + 38'(p7);
    s_nxt   = 39'(t_r) + 39'(v1s_r);

    r = bpc_pkg::tdiv(80'(s_r), 7'd4);
    if (pside_r[4].status != bpc_pkg::ST_OK || r < 80'sd0) begin
      out_press_nxt = '0;
    end else if (r > bpc_pkg::MaxPress) begin
      out_press_nxt = 20'hFFFFF;
    end else begin
      out_press_nxt = 20'(r);
    end
    out_temp_nxt = (pside_r[4].status == bpc_pkg::ST_NO_PRESS) ? 16'sd0 : pside_r[4].temp;
  end

  always_ff @(posedge clk) begin
    p1q_r <= p1q_nxt;
    p2q_r <= p1q_r;
    p3q_r <= p2q_r;
    sq_r  <= sq_nxt;
    pp8_r <= pp8_nxt;
    y_r   <= y_nxt;
    v2q_r <= v2q_nxt;
    v1s_r <= v1s_nxt;
    t_r   <= t_nxt;
    s_r   <= s_nxt;
    pside_r[0] <= dq_side;
    for (int k = 1; k < 5; k++) begin
      pside_r[k] <= pside_r[k-1];
    end
    out_st_r    <= pside_r[4].status;
    out_temp_r  <= out_temp_nxt;
    out_press_r <= out_press_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pvld_r      <= {pvld_r[3:0], dq_vld};
      out_valid_r <= pvld_r[4];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_st_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_pressure_pa        = out_press_r;

endmodule
`default_nettype wire

// ----- design/bpc_checker.sv -----
// Port-level checker for the compensation core, bound to the top level.
// Uses bpc_pkg for status codes and the fixed latency.
`default_nettype none
module bpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [19:0] in_raw_pressure,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic signed [15:0] out_temperature_tenths,
  input wire logic [19:0] out_pressure_pa
);

  a_no_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bpc_pkg::ST_NO_PRESS |->
      out_pressure_pa == 20'd0 && out_temperature_tenths == 16'sd0)
    else $error("no-pressure beat carries nonzero fields");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bpc_pkg::ST_DIV_ZERO |-> out_pressure_pa == 20'd0)
    else $error("zero-divisor beat carries a pressure");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(bpc_pkg::Latency) out_valid)
    else $error("result beat missing after fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, bpc_pkg::Latency))
    else $error("result beat without a matching input beat");

  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_raw_pressure == 20'd0 |->
      ##(bpc_pkg::Latency) out_status == bpc_pkg::ST_NO_PRESS)
    else $error("zero raw pressure not flagged");

endmodule

bind baro_temp_pressure_compensation_core bpc_checker u_bpc_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for baro_temp_pressure_compensation_core: it sends raw readings through
// the start and raw input ports, predicts every result in wide fixed point, and checks each result.
// Depends on bpc_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    bpc_pkg::status_t   status;
    logic signed [15:0] temp;
    logic        [19:0] press;
  } reading_t;

  localparam int CycleLimit = 400000;
  localparam logic [47:0] TypTemp  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypPressA = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TypPressB = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TypPressC = {16'd6000, 16'hC6F8, 16'd15500};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [15:0] out_temperature_tenths;
  logic [19:0] out_pressure_pa;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  logic [47:0] calib [4];
  reading_t pending_readings[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int checked = 0;
  bit idle_on = 1'b1;

  baro_temp_pressure_compensation_core dut (.*);

  always #5 clk = ~clk;

  function automatic wide_t clamp32(wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp);
    wide_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    wide_t d, v1, v2, tf, tmp, a, b, den, p;
    reading_t r;
    r.status = bpc_pkg::ST_OK;
    r.temp = '0;
    r.press = '0;
    if (rp == 0) begin
      r.status = bpc_pkg::ST_NO_PRESS;
      return r;
    end
    t1 = wide_t'(calib[bpc_pkg::REG_TEMP][15:0]);
    t2 = wide_t'($signed(calib[bpc_pkg::REG_TEMP][31:16]));
    t3 = wide_t'($signed(calib[bpc_pkg::REG_TEMP][47:32]));
    p1 = wide_t'(calib[bpc_pkg::REG_PRESS_A][15:0]);
    p2 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_A][31:16]));
    p3 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_A][47:32]));
    p4 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_B][15:0]));
    p5 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_B][31:16]));
    p6 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_B][47:32]));
    p7 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_C][15:0]));
    p8 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_C][31:16]));
    p9 = wide_t'($signed(calib[bpc_pkg::REG_PRESS_C][47:32]));
    d = wide_t'(rt) - 128'sd16 * t1;
    v1 = clamp32(d * t2 / 128'sd16384);
    v2 = clamp32(d * d * t3 / (128'sd1 <<< 34));
    tf = clamp32(v1 + v2);
    tmp = tf / 128'sd512;
    if (tmp > 128'sd32767) tmp = 128'sd32767;
    if (tmp < -128'sd32768) tmp = -128'sd32768;
    r.temp = tmp[15:0];
    a = clamp32((tf - 128'sd128000) / 128'sd2);
    v2 = clamp32(a * a * p6 / 128'sd32768);
    v2 = clamp32(v2 + a * p5 * 128'sd2);
    v2 = clamp32((v2 + p4 * 128'sd262144) / 128'sd4);
    b = clamp32((p3 * a * a + p2 * a * 128'sd524288) / (128'sd1 <<< 38));
    v1 = clamp32((128'sd32768 + b) * p1 / 128'sd32768);
    if (v1 == 0) begin
      r.status = bpc_pkg::ST_DIV_ZERO;
      return r;
    end
    p = 128'sd1048576 - wide_t'(rp);
    den = v1 * 128'sd4096;
    p = clamp32((p * 128'sd4096 - v2) * 128'sd6250 / den);
    v1 = clamp32(p * p * p9 / (128'sd1 <<< 31));
    v2 = clamp32(p * p8 / 128'sd32768);
    p = clamp32((128'sd16 * p + v1 + v2 + p7) / 128'sd16);
    if (p < 0) p = 0;
    if (p > 128'sd1048575) p = 128'sd1048575;
    r.press = p[19:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pending_readings.push_back(compensate(in_raw_temperature, in_raw_pressure));
    end
  end

  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_valid) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        e = pending_readings.pop_front();
        checked++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          errors++;
        end
        if (out_temperature_tenths !== e.temp) begin
          $error("temperature_tenths: expected %0d, actual %0d", e.temp,
                 out_temperature_tenths);
          errors++;
        end
        if (out_pressure_pa !== e.press) begin
          $error("pressure_pa: expected %0d, actual %0d", e.press, out_pressure_pa);
          errors++;
        end
      end
    end
  end

  task automatic write_calib(bpc_pkg::reg_idx_t idx, logic [47:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 5'(idx) << 3;
    pwdata = {16'h0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    calib[idx] = value;
  endtask

  task automatic set_calibration(logic [47:0] t, logic [47:0] a, logic [47:0] b,
                                 logic [47:0] c);
    write_calib(bpc_pkg::REG_TEMP, t);
    write_calib(bpc_pkg::REG_PRESS_A, a);
    write_calib(bpc_pkg::REG_PRESS_B, b);
    write_calib(bpc_pkg::REG_PRESS_C, c);
  endtask

  task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start = 1'b1;
    in_raw_temperature = rt;
    in_raw_pressure = rp;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (bpc_pkg::Latency + 4) @(negedge clk);
  endtask

  task automatic send_typical_mix(int count);
    logic [19:0] rt, rp;
    repeat (count) begin
      if ($urandom_range(0, 9) < 7) begin
        rt = 20'($urandom_range(419888, 619888));
        rp = 20'($urandom_range(265148, 565148));
      end else begin
        rt = 20'($urandom);
        rp = ($urandom_range(0, 19) == 0) ? 20'd0 : 20'($urandom);
      end
      send_reading(rt, rp);
    end
  endtask

  task automatic test_reset_calibration;
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  task automatic test_directed_readings;
    set_calibration(TypTemp, TypPressA, TypPressB, TypPressC);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd519888, 20'd0);
    send_reading(20'd0, 20'd1);
    send_reading(20'hFFFFF, 20'd1);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'd440064, 20'd415148);
    send_reading(20'd600000, 20'd200000);
    send_reading(20'd400000, 20'd700000);
    send_reading(20'h80000, 20'h80000);
    drain();
  endtask

  task automatic test_calibration_extremes;
    set_calibration('1, '1, '1, '1);
    send_reading(20'd0, 20'd1);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd519888, 20'd415148);
    drain();
    set_calibration({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_reading(20'd0, 20'd1);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd524272, 20'd415148);
    drain();
    set_calibration({3{16'h8000}}, {{2{16'h8000}}, 16'hFFFF}, {3{16'h8000}},
                    {3{16'h8000}});
    send_reading(20'd0, 20'd1);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd524272, 20'd600000);
    drain();
    set_calibration(TypTemp, {TypPressA[47:16], 16'd0}, TypPressB, TypPressC);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd519888, 20'd0);
    drain();
  endtask

  task automatic test_random_readings;
    logic [47:0] cal [4];
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        cal = '{TypTemp, TypPressA, TypPressB, TypPressC};
      end else if (phase < 5) begin
        cal[0] = {TypTemp[47:32] + 16'($urandom_range(0, 400)) - 16'd200,
                  TypTemp[31:16] + 16'($urandom_range(0, 4000)) - 16'd2000,
                  TypTemp[15:0] + 16'($urandom_range(0, 4000)) - 16'd2000};
        cal[1] = {TypPressA[47:16], TypPressA[15:0] + 16'($urandom_range(0, 8000)) - 16'd4000};
        cal[2] = {TypPressB[47:32], 16'($urandom_range(0, 300)),
                  TypPressB[15:0] + 16'($urandom_range(0, 2000)) - 16'd1000};
        cal[3] = {TypPressC[47:16] + 32'($urandom_range(0, 2000)) - 32'd1000,
                  TypPressC[15:0]};
      end else begin
        foreach (cal[i]) cal[i] = {16'($urandom), 32'($urandom)};
      end
      if (phase == 7) idle_on = 1'b0;
      set_calibration(cal[0], cal[1], cal[2], cal[3]);
      send_typical_mix(160);
      drain();
    end
  endtask

  initial begin
    foreach (calib[i]) calib[i] = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_reset_calibration();
    test_directed_readings();
    test_calibration_extremes();
    test_random_readings();
    $display("Sent %0d readings across %0d calibration settings; %0d results checked.",
             sent, 14, checked);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
